// ----- hw/rtl/sm83_alu_8bit_unit_macros.svh -----
// Assertion macros for the checker file of the SM83 eight-bit ALU.
// Self-contained; relies on no other file.
`ifndef SM83_ALU_8BIT_UNIT_MACROS_SVH
`define SM83_ALU_8BIT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SM83_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sm83 alu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SM83_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sm83 alu: next-cycle check failed");

`endif

// ----- hw/rtl/sm83_pkg.sv -----
// Package for the SM83 eight-bit ALU: operation codes and payload structs.
// Depends on nothing; used by the core, the top level and the checker.
package sm83_pkg;

    localparam int unsigned OP_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_DAA  = 5'd10,
        OP_CPL  = 5'd11,
        OP_SCF  = 5'd12,
        OP_CCF  = 5'd13,
        OP_RLCA = 5'd14,
        OP_RRCA = 5'd15,
        OP_RLA  = 5'd16,
        OP_RRA  = 5'd17,
        OP_RLC  = 5'd18,
        OP_RRC  = 5'd19,
        OP_RL   = 5'd20,
        OP_RR   = 5'd21,
        OP_SLA  = 5'd22,
        OP_SRA  = 5'd23,
        OP_SWAP = 5'd24,
        OP_SRL  = 5'd25,
        OP_BIT  = 5'd26,
        OP_RES  = 5'd27,
        OP_SET  = 5'd28
    } op_t;

    // Shift kinds shared by the accumulator rotates and the CB group.
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } shift_t;

    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_HIGH   = 8'h60;
    localparam logic [7:0] DAA_LOW    = 8'h06;
    localparam logic [3:0] NIBBLE_MAX = 4'h9;

    typedef struct packed {
        logic [OP_W-1:0] req_type;
        logic [7:0]      a_value;
        logic [7:0]      b_value;
        logic [2:0]      bit_index;
        logic            z_in;
        logic            n_in;
        logic            h_in;
        logic            c_in;
    } req_t;

    typedef struct packed {
        logic [7:0] result;
        logic       write_back;
        logic       z_out;
        logic       n_out;
        logic       h_out;
        logic       c_out;
    } rsp_t;

endpackage

// ----- hw/rtl/sm83_if.sv -----
// Valid/ready channel interfaces for the request and result words of the ALU.
// Depends on nothing.
interface sm83_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] req_type;
    logic [7:0] a_value;
    logic [7:0] b_value;
    logic [2:0] bit_index;
    logic       z_in;
    logic       n_in;
    logic       h_in;
    logic       c_in;

    modport source (
        output valid, req_type, a_value, b_value, bit_index, z_in, n_in, h_in, c_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, a_value, b_value, bit_index, z_in, n_in, h_in, c_in,
        output ready
    );
endinterface

interface sm83_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic       write_back;
    logic       z_out;
    logic       n_out;
    logic       h_out;
    logic       c_out;

    modport source (
        output valid, result, write_back, z_out, n_out, h_out, c_out,
        input  ready
    );
    modport sink (
        input  valid, result, write_back, z_out, n_out, h_out, c_out,
        output ready
    );
endinterface

// ----- hw/rtl/sm83_alu_core.sv -----
// Combinational SM83 ALU datapath: one request word in, one result word out.
// Depends on sm83_pkg.
module sm83_alu_core
    import sm83_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);

    function automatic logic [8:0] shift_byte(
        input logic [2:0] kind,
        input logic [7:0] v,
        input logic       cin
    );
        logic [7:0] r;
        logic       c;
        begin
            case (kind)
                SH_RLC:  begin c = v[7]; r = {v[6:0], v[7]}; end
                SH_RRC:  begin c = v[0]; r = {v[0], v[7:1]}; end
                SH_RL:   begin c = v[7]; r = {v[6:0], cin}; end
                SH_RR:   begin c = v[0]; r = {cin, v[7:1]}; end
                SH_SLA:  begin c = v[7]; r = {v[6:0], 1'b0}; end
                SH_SRA:  begin c = v[0]; r = {v[7], v[7:1]}; end
                SH_SWAP: begin c = 1'b0; r = {v[3:0], v[7:4]}; end
                default: begin c = v[0]; r = {1'b0, v[7:1]}; end
            endcase
            return {c, r};
        end
    endfunction

    logic [7:0] a;
    logic [7:0] b;
    logic       cy_add;
    logic       cy_sub;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] diff9;
    logic [4:0] diff_lo;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic [7:0] daa_adj;
    logic       daa_c;
    logic [7:0] daa_val;
    logic [2:0] acc_kind;
    logic [2:0] cb_kind;
    logic [8:0] acc_sh;
    logic [8:0] cb_sh;
    logic [7:0] bit_mask;
    logic [7:0] r;

    assign a = req.a_value;
    assign b = req.b_value;
    assign cy_add = (req.req_type == OP_ADC) && req.c_in;
    assign cy_sub = (req.req_type == OP_SBC) && req.c_in;

    // The ninth bit of the subtraction is the borrow out.
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cy_add};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy_add};
    assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, cy_sub};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy_sub};
    assign inc_val = a + 8'd1;
    assign dec_val = a - 8'd1;

    always_comb
    begin
        daa_adj = 8'd0;
        daa_c   = req.c_in;
        if (req.h_in || (!req.n_in && (a[3:0] > NIBBLE_MAX)))
        begin
            daa_adj = DAA_LOW;
        end
        if (req.c_in || (!req.n_in && (a > DAA_LIMIT)))
        begin
            daa_adj = daa_adj | DAA_HIGH;
            daa_c   = 1'b1;
        end
    end

    assign daa_val  = req.n_in ? (a - daa_adj) : (a + daa_adj);
    assign acc_kind = 3'(req.req_type - OP_RLCA);
    assign cb_kind  = 3'(req.req_type - OP_RLC);
    assign acc_sh   = shift_byte(acc_kind, a, req.c_in);
    assign cb_sh    = shift_byte(cb_kind, a, req.c_in);
    assign bit_mask = 8'd1 << req.bit_index;

    always_comb
    begin
        r              = a;
        rsp.write_back = 1'b1;
        rsp.z_out      = req.z_in;
        rsp.n_out      = req.n_in;
        rsp.h_out      = req.h_in;
        rsp.c_out      = req.c_in;
        case (req.req_type)
            OP_ADD, OP_ADC:
            begin
                r         = sum9[7:0];
                rsp.z_out = (sum9[7:0] == 8'd0);
                rsp.n_out = 1'b0;
                rsp.h_out = sum_lo[4];
                rsp.c_out = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r              = diff9[7:0];
                rsp.z_out      = (diff9[7:0] == 8'd0);
                rsp.n_out      = 1'b1;
                rsp.h_out      = diff_lo[4];
                rsp.c_out      = diff9[8];
                rsp.write_back = (req.req_type != OP_CP);
            end
            OP_AND:
            begin
                r         = a & b;
                rsp.z_out = ((a & b) == 8'd0);
                rsp.n_out = 1'b0;
                rsp.h_out = 1'b1;
                rsp.c_out = 1'b0;
            end
            OP_XOR:
            begin
                r         = a ^ b;
                rsp.z_out = ((a ^ b) == 8'd0);
                rsp.n_out = 1'b0;
                rsp.h_out = 1'b0;
                rsp.c_out = 1'b0;
            end
            OP_OR:
            begin
                r         = a | b;
                rsp.z_out = ((a | b) == 8'd0);
                rsp.n_out = 1'b0;
                rsp.h_out = 1'b0;
                rsp.c_out = 1'b0;
            end
            OP_INC:
            begin
                r         = inc_val;
                rsp.z_out = (inc_val == 8'd0);
                rsp.n_out = 1'b0;
                rsp.h_out = (inc_val[3:0] == 4'h0);
            end
            OP_DEC:
            begin
                r         = dec_val;
                rsp.z_out = (dec_val == 8'd0);
                rsp.n_out = 1'b1;
                rsp.h_out = (dec_val[3:0] == 4'hF);
            end
            OP_DAA:
            begin
                r         = daa_val;
                rsp.z_out = (daa_val == 8'd0);
                rsp.h_out = 1'b0;
                rsp.c_out = daa_c;
            end
            OP_CPL:
            begin
                r         = ~a;
                rsp.n_out = 1'b1;
                rsp.h_out = 1'b1;
            end
            OP_SCF:
            begin
                rsp.write_back = 1'b0;
                rsp.n_out      = 1'b0;
                rsp.h_out      = 1'b0;
                rsp.c_out      = 1'b1;
            end
            OP_CCF:
            begin
                rsp.write_back = 1'b0;
                rsp.n_out      = 1'b0;
                rsp.h_out      = 1'b0;
                rsp.c_out      = ~req.c_in;
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                r         = acc_sh[7:0];
                rsp.z_out = 1'b0;
                rsp.n_out = 1'b0;
                rsp.h_out = 1'b0;
                rsp.c_out = acc_sh[8];
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL:
            begin
                r         = cb_sh[7:0];
                rsp.z_out = (cb_sh[7:0] == 8'd0);
                rsp.n_out = 1'b0;
                rsp.h_out = 1'b0;
                rsp.c_out = cb_sh[8];
            end
            OP_BIT:
            begin
                rsp.write_back = 1'b0;
                rsp.z_out      = ((a & bit_mask) == 8'd0);
                rsp.n_out      = 1'b0;
                rsp.h_out      = 1'b1;
            end
            OP_RES:
            begin
                r = a & ~bit_mask;
            end
            OP_SET:
            begin
                r = a | bit_mask;
            end
            default:
            begin
                // Unassigned codes behave as a no-operation.
                rsp.write_back = 1'b0;
            end
        endcase
        rsp.result = r;
    end

endmodule

// ----- hw/rtl/sm83_alu_8bit_unit.sv -----
// SM83 eight-bit ALU, two-stage valid/ready pipeline.
// Each accepted word is held in req_reg, passes through the core and is held in rsp_reg, which drives rsp.
// Throughput: one word per cycle; the ALU is a single pass between two registers.
// Output back-pressure stalls the input only once both stages hold a word; no bubbles.
// Reset (rst_n low, asynchronous) empties both stages; payload is not cleared.
// Depends on sm83_pkg, sm83_if and sm83_alu_core.
module sm83_alu_8bit_unit
    import sm83_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sm83_req_if.sink        req,
    sm83_rsp_if.source      rsp
);

    req_t req_reg;
    req_t req_next;
    logic in_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic out_valid_reg;
    logic out_free;
    logic in_free;

    assign out_free = !out_valid_reg || rsp.ready;
    assign in_free  = !in_valid_reg || out_free;
    assign req.ready = in_free;

    assign req_next.req_type  = req.req_type;
    assign req_next.a_value   = req.a_value;
    assign req_next.b_value   = req.b_value;
    assign req_next.bit_index = req.bit_index;
    assign req_next.z_in      = req.z_in;
    assign req_next.n_in      = req.n_in;
    assign req_next.h_in      = req.h_in;
    assign req_next.c_in      = req.c_in;

    sm83_alu_core u_core (
        .req (req_reg),
        .rsp (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && req.valid)
        begin
            req_reg <= req_next;
        end
        if (out_free && in_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.result     = rsp_reg.result;
    assign rsp.write_back = rsp_reg.write_back;
    assign rsp.z_out      = rsp_reg.z_out;
    assign rsp.n_out      = rsp_reg.n_out;
    assign rsp.h_out      = rsp_reg.h_out;
    assign rsp.c_out      = rsp_reg.c_out;

endmodule

// ----- hw/rtl/sm83_chk.sv -----
// Port-level checker for the SM83 eight-bit ALU, bound to the top level.
// Depends on sm83_pkg, sm83_if and sm83_alu_8bit_unit_macros.svh.
`include "sm83_alu_8bit_unit_macros.svh"

module sm83_chk
    import sm83_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sm83_req_if.sink        req,
    sm83_rsp_if.source      rsp
);

    logic        req_fire;
    logic        scf_fire;
    logic        rsp_stall;
    logic [12:0] rsp_word;
    logic        scf_flags_ok;

    assign req_fire     = req.valid && req.ready;
    assign scf_fire     = req_fire && (req.req_type == OP_SCF);
    assign rsp_stall    = rsp.valid && !rsp.ready;
    assign rsp_word     = {rsp.result, rsp.write_back,
                           rsp.z_out, rsp.n_out, rsp.h_out, rsp.c_out};
    assign scf_flags_ok = rsp.valid && !rsp.write_back && rsp.c_out
                          && !rsp.n_out && !rsp.h_out;

    // A result word waiting on the sink keeps its value.
    `SM83_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp.valid && $stable(rsp_word))

    // An empty output stage never blocks the input side.
    `SM83_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !rsp.valid, req.ready)

    // An accepted word passes through both stages to rsp without waiting when the sink is ready.
    `SM83_ASSERT_NEXT(a_latency, clk, rst_n, req_fire ##1 rsp.ready, rsp.valid)

    // Set-carry leaves the target alone, sets C and clears N and H.
    `SM83_ASSERT_NEXT(a_scf_flags, clk, rst_n, scf_fire ##1 rsp.ready, scf_flags_ok)

endmodule

bind sm83_alu_8bit_unit sm83_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

// ----- verif/sm83_alu_8bit_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the SM83 eight-bit ALU unit: a directed table, then random words.
// Depends on sm83_pkg, the sm83_req_if/sm83_rsp_if interfaces and sm83_alu_8bit_unit.
module sm83_alu_8bit_unit_test;
    import sm83_pkg::*;

    localparam int          CLK_HALF_NS      = 10;
    localparam int          RESET_CYCLES     = 11;
    localparam int          IDLE_PERCENT     = 20;
    localparam int          SINK_HOLD_CYCLES = 150;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          RANDOM_SETTLE    = 300;
    localparam int          RANDOM_BACKLOG   = 100;
    localparam int          RANDOM_STEADY    = 200;
    localparam int          RANDOM_TAIL      = 220;
    localparam logic [4:0]  OP_UNUSED        = 5'd31;
    localparam logic [4:0]  OP_FIRST_UNUSED  = 5'd29;
    localparam int          DIRECTED_COUNT   = 31;

    // One row of the directed table; want is only meaningful when typed is set.
    typedef struct packed {
        req_t word;
        logic typed;
        rsp_t want;
    } row_t;

    // Row layout: op, a, b, bit index, flags ZNHC, typed, result, write-back, flags ZNHC.
    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        {OP_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000, 1'b1, 8'h00, 1'b1, 4'b1011},
        {OP_ADC,  8'hFF, 8'h00, 3'd0, 4'b0001, 1'b1, 8'h00, 1'b1, 4'b1011},
        {OP_SUB,  8'h00, 8'h01, 3'd0, 4'b0000, 1'b1, 8'hFF, 1'b1, 4'b0111},
        {OP_SBC,  8'h00, 8'h00, 3'd0, 4'b0001, 1'b1, 8'hFF, 1'b1, 4'b0111},
        {OP_AND,  8'hFF, 8'h00, 3'd0, 4'b0000, 1'b1, 8'h00, 1'b1, 4'b1010},
        {OP_XOR,  8'hFF, 8'hFF, 3'd0, 4'b0111, 1'b1, 8'h00, 1'b1, 4'b1000},
        {OP_OR,   8'h00, 8'h00, 3'd0, 4'b1111, 1'b1, 8'h00, 1'b1, 4'b1000},
        {OP_CP,   8'h55, 8'h55, 3'd0, 4'b0000, 1'b1, 8'h00, 1'b0, 4'b1100},
        {OP_INC,  8'hFF, 8'h00, 3'd0, 4'b0001, 1'b1, 8'h00, 1'b1, 4'b1011},
        {OP_DEC,  8'h00, 8'h00, 3'd0, 4'b0000, 1'b1, 8'hFF, 1'b1, 4'b0110},
        {OP_UNUSED, 8'hA5, 8'hFF, 3'd7, 4'b1010, 1'b1, 8'hA5, 1'b0, 4'b1010},
        {OP_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_DAA,  8'h00, 8'h00, 3'd0, 4'b0111, 1'b0, 13'd0},
        {OP_CPL,  8'h00, 8'h00, 3'd0, 4'b1001, 1'b0, 13'd0},
        {OP_SCF,  8'h3C, 8'h00, 3'd0, 4'b1110, 1'b0, 13'd0},
        {OP_CCF,  8'h3C, 8'h00, 3'd0, 4'b0001, 1'b0, 13'd0},
        {OP_RLCA, 8'h80, 8'h00, 3'd0, 4'b1000, 1'b0, 13'd0},
        {OP_RRCA, 8'h01, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_RLA,  8'h80, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_RRA,  8'h01, 8'h00, 3'd0, 4'b0001, 1'b0, 13'd0},
        {OP_RLC,  8'h00, 8'h00, 3'd0, 4'b0001, 1'b0, 13'd0},
        {OP_RRC,  8'h01, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_RL,   8'h80, 8'h00, 3'd0, 4'b0001, 1'b0, 13'd0},
        {OP_RR,   8'h01, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_SLA,  8'h80, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_SRA,  8'h81, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_SWAP, 8'hF0, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_SRL,  8'h01, 8'h00, 3'd0, 4'b0000, 1'b0, 13'd0},
        {OP_BIT,  8'h7F, 8'h00, 3'd7, 4'b0001, 1'b0, 13'd0},
        {OP_RES,  8'hFF, 8'h00, 3'd0, 4'b1111, 1'b0, 13'd0},
        {OP_SET,  8'h00, 8'h00, 3'd7, 4'b0000, 1'b0, 13'd0}
    };

    logic clk;
    logic rst_n;

    sm83_req_if req_ch ();
    sm83_rsp_if rsp_ch ();

    sm83_alu_8bit_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rsp_t pending_results [$];
    int   mismatch_count;
    bit   idle_enable;
    int   hold_asked;
    int   hold_served;
    logic offer_typed;
    rsp_t offer_want;

    initial begin
        clk = 1'b0;
        forever begin
            #CLK_HALF_NS clk = ~clk;
        end
    end

    // Bit-accurate model of the ALU: one request word in, one result word out.
    function automatic rsp_t alu_result_of(input req_t w);
        rsp_t       o;
        op_t        op;
        logic [8:0] wide;
        logic [4:0] nib;
        logic [7:0] adj;
        logic [2:0] kind;
        logic       cy;
        logic       cb_group;
        begin
            op = op_t'(w.req_type);
            o.result     = w.a_value;
            o.write_back = 1'b1;
            o.z_out      = w.z_in;
            o.n_out      = w.n_in;
            o.h_out      = w.h_in;
            o.c_out      = w.c_in;
            case (op)
                OP_ADD, OP_ADC: begin
                    cy = (op == OP_ADC) ? w.c_in : 1'b0;
                    wide = {1'b0, w.a_value} + {1'b0, w.b_value} + {8'd0, cy};
                    nib = {1'b0, w.a_value[3:0]} + {1'b0, w.b_value[3:0]} + {4'd0, cy};
                    o.result = wide[7:0];
                    o.z_out  = (wide[7:0] == 8'd0);
                    o.n_out  = 1'b0;
                    o.h_out  = nib[4];
                    o.c_out  = wide[8];
                end
                OP_SUB, OP_SBC, OP_CP: begin
                    cy = (op == OP_SBC) ? w.c_in : 1'b0;
                    // A borrow out of the nibble or the byte shows as the top bit.
                    wide = {1'b0, w.a_value} - {1'b0, w.b_value} - {8'd0, cy};
                    nib = {1'b0, w.a_value[3:0]} - {1'b0, w.b_value[3:0]} - {4'd0, cy};
                    o.result     = wide[7:0];
                    o.z_out      = (wide[7:0] == 8'd0);
                    o.n_out      = 1'b1;
                    o.h_out      = nib[4];
                    o.c_out      = wide[8];
                    o.write_back = (op != OP_CP);
                end
                OP_AND: begin
                    o.result = w.a_value & w.b_value;
                    o.z_out  = (o.result == 8'd0);
                    o.n_out  = 1'b0;
                    o.h_out  = 1'b1;
                    o.c_out  = 1'b0;
                end
                OP_XOR, OP_OR: begin
                    o.result = (op == OP_XOR) ? (w.a_value ^ w.b_value) : (w.a_value | w.b_value);
                    o.z_out  = (o.result == 8'd0);
                    o.n_out  = 1'b0;
                    o.h_out  = 1'b0;
                    o.c_out  = 1'b0;
                end
                OP_INC: begin
                    o.result = w.a_value + 8'd1;
                    o.z_out  = (o.result == 8'd0);
                    o.n_out  = 1'b0;
                    o.h_out  = (o.result[3:0] == 4'h0);
                end
                OP_DEC: begin
                    o.result = w.a_value - 8'd1;
                    o.z_out  = (o.result == 8'd0);
                    o.n_out  = 1'b1;
                    o.h_out  = (o.result[3:0] == 4'hF);
                end
                OP_DAA: begin
                    adj = 8'd0;
                    cy  = w.c_in;
                    if (w.h_in || (!w.n_in && w.a_value[3:0] > NIBBLE_MAX))
                        adj = DAA_LOW;
                    if (w.c_in || (!w.n_in && w.a_value > DAA_LIMIT))
                    begin
                        adj = adj | DAA_HIGH;
                        cy  = 1'b1;
                    end
                    o.result = w.n_in ? (w.a_value - adj) : (w.a_value + adj);
                    o.z_out  = (o.result == 8'd0);
                    o.h_out  = 1'b0;
                    o.c_out  = cy;
                end
                OP_CPL: begin
                    o.result = ~w.a_value;
                    o.n_out  = 1'b1;
                    o.h_out  = 1'b1;
                end
                OP_SCF, OP_CCF: begin
                    o.write_back = 1'b0;
                    o.n_out      = 1'b0;
                    o.h_out      = 1'b0;
                    o.c_out      = (op == OP_SCF) ? 1'b1 : ~w.c_in;
                end
                OP_RLCA, OP_RRCA, OP_RLA, OP_RRA,
                OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                    cb_group = (op >= OP_RLC);
                    kind = cb_group ? 3'(w.req_type - OP_RLC) : 3'(w.req_type - OP_RLCA);
                    case (shift_t'(kind))
                        SH_RLC: begin
                            cy = w.a_value[7];
                            o.result = {w.a_value[6:0], w.a_value[7]};
                        end
                        SH_RRC: begin
                            cy = w.a_value[0];
                            o.result = {w.a_value[0], w.a_value[7:1]};
                        end
                        SH_RL: begin
                            cy = w.a_value[7];
                            o.result = {w.a_value[6:0], w.c_in};
                        end
                        SH_RR: begin
                            cy = w.a_value[0];
                            o.result = {w.c_in, w.a_value[7:1]};
                        end
                        SH_SLA: begin
                            cy = w.a_value[7];
                            o.result = {w.a_value[6:0], 1'b0};
                        end
                        SH_SRA: begin
                            cy = w.a_value[0];
                            o.result = {w.a_value[7], w.a_value[7:1]};
                        end
                        SH_SWAP: begin
                            cy = 1'b0;
                            o.result = {w.a_value[3:0], w.a_value[7:4]};
                        end
                        default: begin
                            cy = w.a_value[0];
                            o.result = {1'b0, w.a_value[7:1]};
                        end
                    endcase
                    // The accumulator rotates always clear Z.
                    o.z_out = cb_group && (o.result == 8'd0);
                    o.n_out = 1'b0;
                    o.h_out = 1'b0;
                    o.c_out = cy;
                end
                OP_BIT: begin
                    o.write_back = 1'b0;
                    o.z_out      = ~w.a_value[w.bit_index];
                    o.n_out      = 1'b0;
                    o.h_out      = 1'b1;
                end
                OP_RES: o.result = w.a_value & ~(8'd1 << w.bit_index);
                OP_SET: o.result = w.a_value | (8'd1 << w.bit_index);
                default: o.write_back = 1'b0;
            endcase
            return o;
        end
    endfunction

    // Operands lean towards the values where carries and decimal adjust change behaviour.
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h99;
            3: return 8'h9A;
            4: return {4'($urandom_range(15)), 4'hF};
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic req_t random_word();
        req_t w;
        begin
            if ($urandom_range(99) < 3)
                w.req_type = 5'($urandom_range(OP_UNUSED, OP_FIRST_UNUSED));
            else
                w.req_type = 5'($urandom_range(OP_SET, OP_ADD));
            w.a_value   = pick_operand();
            w.b_value   = pick_operand();
            w.bit_index = 3'($urandom_range(7));
            {w.z_in, w.n_in, w.h_in, w.c_in} = 4'($urandom_range(15));
            return w;
        end
    endfunction

    // Called just after a falling edge; returns at the falling edge after the word is taken.
    task automatic offer_word(input req_t word, input logic typed, input rsp_t want);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= word.req_type;
        req_ch.a_value   <= word.a_value;
        req_ch.b_value   <= word.b_value;
        req_ch.bit_index <= word.bit_index;
        req_ch.z_in      <= word.z_in;
        req_ch.n_in      <= word.n_in;
        req_ch.h_in      <= word.h_in;
        req_ch.c_in      <= word.c_in;
        offer_typed      <= typed;
        offer_want       <= want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: random back-pressure, plus long hold-offs on request.
    initial begin
        rsp_ch.ready = 1'b0;
        hold_served  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_served + 1;
                repeat (SINK_HOLD_CYCLES)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            rsp_ch.ready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Record what each accepted word should produce, and check each result word.
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(offer_typed ? offer_want : alu_result_of({
                    req_ch.req_type, req_ch.a_value, req_ch.b_value, req_ch.bit_index,
                    req_ch.z_in, req_ch.n_in, req_ch.h_in, req_ch.c_in}));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.result, rsp_ch.write_back,
                       rsp_ch.z_out, rsp_ch.n_out, rsp_ch.h_out, rsp_ch.c_out};
                if (pending_results.size() == 0)
                begin
                    $error("result word %h arrived with no word outstanding", got);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.result !== want.result)
                        $error("result: expected %h, actual %h", want.result, got.result);
                    if (got.write_back !== want.write_back)
                        $error("write_back: expected %b, actual %b",
                               want.write_back, got.write_back);
                    if (got.z_out !== want.z_out)
                        $error("z_out: expected %b, actual %b", want.z_out, got.z_out);
                    if (got.n_out !== want.n_out)
                        $error("n_out: expected %b, actual %b", want.n_out, got.n_out);
                    if (got.h_out !== want.h_out)
                        $error("h_out: expected %b, actual %b", want.h_out, got.h_out);
                    if (got.c_out !== want.c_out)
                        $error("c_out: expected %b, actual %b", want.c_out, got.c_out);
                    if (got !== want)
                        mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        rst_n            = 1'b0;
        mismatch_count   = 0;
        idle_enable      = 1'b1;
        hold_asked       = 0;
        offer_typed      = 1'b0;
        offer_want       = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = OP_ADD;
        req_ch.a_value   = 8'h00;
        req_ch.b_value   = 8'h00;
        req_ch.bit_index = 3'd0;
        req_ch.z_in      = 1'b0;
        req_ch.n_in      = 1'b0;
        req_ch.h_in      = 1'b0;
        req_ch.c_in      = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int i = 0; i < RANDOM_SETTLE; i++)
            offer_word(random_word(), 1'b0, '0);

        // Let the pipeline run dry before going on.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);

        // The result side holds off while words keep coming, so the input must stall.
        idle_enable = 1'b0;
        hold_asked  = hold_asked + 1;
        for (int i = 0; i < RANDOM_BACKLOG; i++)
            offer_word(random_word(), 1'b0, '0);

        for (int i = 0; i < RANDOM_STEADY; i++)
            offer_word(random_word(), 1'b0, '0);

        idle_enable = 1'b1;
        for (int i = 0; i < RANDOM_TAIL; i++)
            offer_word(random_word(), 1'b0, '0);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
